/* rtl/cpt_pkg.sv */
// ----------------------------------------------------------------------------
// cpt_pkg: shared constants and helpers
// Default sizes, register indexes, status codes and fixed-point widths for
// the conditional probability table block.
// ----------------------------------------------------------------------------
package cpt_pkg;

    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int MAX_PARENTS_DEF   = 4;
    localparam int MAX_STATES_DEF    = 256;

    localparam int FRAC_W   = 16;          // fraction bits of Q16.16 / Q1.16
    localparam int PROB_W   = FRAC_W + 1;  // Q1.16 probability width
    localparam int CNT_W    = 32;          // count entry width
    localparam int STATES_W = 9;
    localparam int VALUE_W  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_NODE_STATES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARENT_CNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PARENT0     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PARENT1     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PARENT2     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PARENT3     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING   = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1 << FRAC_W);

    // state count as used: zero acts as one, above the limit acts as the limit
    function automatic logic [STATES_W-1:0] eff_states(input logic [STATES_W-1:0] r,
                                                       input int maxs);
        logic [STATES_W-1:0] res;
        if (r == '0) begin
            res = STATES_W'(1);
        end else if (r > STATES_W'(maxs)) begin
            res = STATES_W'(maxs);
        end else begin
            res = r;
        end
        return res;
    endfunction

endpackage

/* rtl/cpt_table_ram.sv */
// ----------------------------------------------------------------------------
// cpt_table_ram: count table storage
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module cpt_table_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/cpt_divider.sv */
// ----------------------------------------------------------------------------
// cpt_divider: iterative quotient unit for normalization
// Restoring division, one quotient bit per cycle, quotient known to fit
// in PROB_W bits.
// ----------------------------------------------------------------------------
module cpt_divider #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 41
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [NUM_W-1:0]          numer,
    input  logic [DEN_W-1:0]          denom,
    output logic                      done,
    output logic [cpt_pkg::PROB_W-1:0] quot
);
    import cpt_pkg::*;

    localparam int DW = DEN_W + PROB_W - 1;
    localparam int STEP_W = $clog2(PROB_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DW-1:0]     rem_reg, rem_next;
    logic [DW-1:0]     dsh_reg, dsh_next;
    logic [PROB_W-1:0] q_reg, q_next;
    logic              ge;

    assign ge = rem_reg >= dsh_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(PROB_W - 1);
            rem_next  = DW'(numer);
            dsh_next  = {denom, {(PROB_W-1){1'b0}}};
            q_next    = '0;
        end else if (busy_reg) begin
            if (ge) begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = {q_reg[PROB_W-2:0], ge};
            dsh_next = dsh_reg >> 1;
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        q_reg    <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

/* rtl/cpt_count_and_normalize.sv */
// ----------------------------------------------------------------------------
// cpt_count_and_normalize: conditional probability table builder
// Counts weighted samples into a table and normalizes its columns.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries requests: sample (tuser op 0) or query (tuser op 1).
//   tuser[1] on a sample refills the table with the smoothing count first,
//   tlast on a sample normalizes every column afterwards. Every request gives
//   one result on the m_ channel: probability in tdata, status in tuser.
//   Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
// Sequence, one request at a time:
//   geometry: column count and flat index built parent by parent, then a size check
//   plain sample: geometry, then read, saturating add, write back
//   refill: one table write per cycle over all TABLE_ENTRIES entries
//   normalize: per column a sum pass and a column step,
//     then per entry read, divider start, 17 divider steps, write back
//   query: geometry and a read, plus a sum pass over the column when a zero
//     column was found at the last normalization
//   the sequence is bound by the single table read port and the divider
// Reset clears control state and loads configuration defaults; the table is
// not cleared and holds no defined data until the first refill.
// A stalled receiver holds the result register; the next request is still
// accepted and is worked up to its result, which then waits for the slot.
// ----------------------------------------------------------------------------
module cpt_count_and_normalize #(
    parameter int TABLE_ENTRIES = cpt_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_PARENTS   = cpt_pkg::MAX_PARENTS_DEF,
    parameter int MAX_STATES    = cpt_pkg::MAX_STATES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // config write port
    input  logic                           cfg_we,
    input  logic [cpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpt_pkg::CFG_DAT_W-1:0]  cfg_wdata,
    // request channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata: node_value[7:0], parent0_value[15:8], parent1_value[23:16],
    //        parent2_value[31:24], parent3_value[39:32], sample_weight[71:40]
    input  logic [71:0]                    s_tdata,
    // tuser: op[0], first_sample[1]
    input  logic [1:0]                     s_tuser,
    input  logic                           s_tlast,   // last_sample
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tdata: probability[16:0], zero fill above
    output logic [23:0]                    m_tdata,
    // tuser: status[1:0]
    output logic [1:0]                     m_tuser
);
    import cpt_pkg::*;

    localparam int AW    = $clog2(TABLE_ENTRIES);
    localparam int CW    = $clog2(TABLE_ENTRIES + 2);   // holds the clamp value
    localparam int SUM_W = CNT_W + $clog2(MAX_STATES + 1);
    localparam int NUM_W = (((SUM_W - 1) > (CNT_W + FRAC_W)) ? (SUM_W - 1)
                                                             : (CNT_W + FRAC_W)) + 1;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_GEO      = 4'd1;
    localparam logic [3:0] S_SIZE     = 4'd2;
    localparam logic [3:0] S_FILL     = 4'd3;
    localparam logic [3:0] S_ADD_RD   = 4'd4;
    localparam logic [3:0] S_ADD_WR   = 4'd5;
    localparam logic [3:0] S_NORM_COL = 4'd6;
    localparam logic [3:0] S_SUM      = 4'd7;
    localparam logic [3:0] S_SUM_DONE = 4'd8;
    localparam logic [3:0] S_DIV_RD   = 4'd9;
    localparam logic [3:0] S_DIV_GO   = 4'd10;
    localparam logic [3:0] S_DIV_WAIT = 4'd11;
    localparam logic [3:0] S_NEXT_COL = 4'd12;
    localparam logic [3:0] S_Q_RD     = 4'd13;
    localparam logic [3:0] S_Q_DATA   = 4'd14;
    localparam logic [3:0] S_FIN      = 4'd15;

    // configuration registers
    logic [STATES_W-1:0] node_states_reg;
    logic [2:0]          parent_count_reg;
    logic [STATES_W-1:0] parent_states_reg [4];
    logic [CNT_W-1:0]    smoothing_reg;

    // sequencer state
    logic [3:0]          state_reg, state_next;
    logic                op_reg, op_next;
    logic                first_reg, first_next;
    logic                last_reg, last_next;
    logic [VALUE_W-1:0]  nv_reg, nv_next;
    logic [VALUE_W-1:0]  pv_reg [4];
    logic [VALUE_W-1:0]  pv_next [4];
    logic [CNT_W-1:0]    w_reg, w_next;
    logic                ok_reg, ok_next;
    logic [2:0]          pi_reg, pi_next;
    logic [CW-1:0]       cols_reg, cols_next;
    logic [AW-1:0]       pflat_reg, pflat_next;
    logic [AW-1:0]       flat_reg, flat_next;
    logic [AW-1:0]       fill_reg, fill_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [STATES_W-1:0] vcnt_reg, vcnt_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                pend_reg, pend_next;
    logic                qpass_reg, qpass_next;     // sum pass serves a query
    logic                zero_reg, zero_next;       // zero column in this pass
    logic                zcs_reg, zcs_next;         // zero column seen
    logic [PROB_W-1:0]   prob_reg, prob_next;
    logic [1:0]          status_reg, status_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [PROB_W-1:0]   m_prob_reg, m_prob_next;
    logic [1:0]          m_status_reg, m_status_next;

    // table port
    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [CNT_W-1:0]    ram_wdata, ram_rdata;

    // divider port
    logic                div_start, div_done;
    logic [NUM_W-1:0]    div_numer;
    logic [PROB_W-1:0]   div_quot;

    // effective geometry
    logic [STATES_W-1:0] ns_eff;
    logic [2:0]          pc_eff;
    logic [STATES_W-1:0] d_cur;
    logic [VALUE_W-1:0]  pv_cur;
    logic [CW+8:0]       cprod;
    logic [AW+8:0]       pprod;
    logic [CW+8:0]       sprod;
    logic [CW+8:0]       fprod;
    logic [CNT_W:0]      sat_sum;
    logic                issue;

    assign ns_eff = eff_states(node_states_reg, MAX_STATES);
    assign pc_eff = (parent_count_reg > 3'(MAX_PARENTS)) ? 3'(MAX_PARENTS)
                                                         : parent_count_reg;
    assign d_cur  = eff_states(parent_states_reg[pi_reg[1:0]], MAX_STATES);
    assign pv_cur = pv_reg[pi_reg[1:0]];
    assign cprod  = (CW+9)'(cols_reg) * (CW+9)'(d_cur);
    assign pprod  = (AW+9)'(pflat_reg) * (AW+9)'(d_cur);
    assign sprod  = (CW+9)'(cols_reg) * (CW+9)'(ns_eff);
    assign fprod  = (CW+9)'(ok_reg ? nv_reg : '0) * (CW+9)'(cols_reg);
    assign sat_sum = {1'b0, ram_rdata} + {1'b0, w_reg};
    assign issue  = vcnt_reg < ns_eff;
    assign div_numer = NUM_W'({ram_rdata, {FRAC_W{1'b0}}}) + NUM_W'(sum_reg >> 1);

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        nv_next       = nv_reg;
        pv_next       = pv_reg;
        w_next        = w_reg;
        ok_next       = ok_reg;
        pi_next       = pi_reg;
        cols_next     = cols_reg;
        pflat_next    = pflat_reg;
        flat_next     = flat_reg;
        fill_next     = fill_reg;
        col_next      = col_reg;
        vcnt_next     = vcnt_reg;
        addr_next     = addr_reg;
        sum_next      = sum_reg;
        pend_next     = pend_reg;
        qpass_next    = qpass_reg;
        zero_next     = zero_reg;
        zcs_next      = zcs_reg;
        prob_next     = prob_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg;
        m_prob_next   = m_prob_reg;
        m_status_next = m_status_reg;
        ram_we        = 1'b0;
        ram_waddr     = flat_reg;
        ram_wdata     = ram_rdata;
        ram_re        = 1'b0;
        ram_raddr     = flat_reg;
        div_start     = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next     = s_tuser[0];
                    first_next  = s_tuser[1];
                    last_next   = s_tlast;
                    nv_next     = s_tdata[7:0];
                    pv_next[0]  = s_tdata[15:8];
                    pv_next[1]  = s_tdata[23:16];
                    pv_next[2]  = s_tdata[31:24];
                    pv_next[3]  = s_tdata[39:32];
                    w_next      = s_tdata[71:40];
                    ok_next     = {1'b0, s_tdata[7:0]} < ns_eff;
                    pi_next     = '0;
                    cols_next   = CW'(1);
                    pflat_next  = '0;
                    prob_next   = '0;
                    status_next = ST_OK;
                    state_next  = S_GEO;
                end
            end
            S_GEO: begin
                // one parent per cycle, column count clamped past the table size
                if (pi_reg < pc_eff) begin
                    if (cprod > (CW+9)'(TABLE_ENTRIES)) begin
                        cols_next = CW'(TABLE_ENTRIES + 1);
                    end else begin
                        cols_next = CW'(cprod);
                    end
                    if ({1'b0, pv_cur} < d_cur) begin
                        pflat_next = AW'(pprod) + AW'(pv_cur);
                    end else begin
                        pflat_next = AW'(pprod);
                        ok_next    = 1'b0;
                    end
                end
                if (pi_reg == 3'(MAX_PARENTS - 1)) begin
                    state_next = S_SIZE;
                end else begin
                    pi_next = pi_reg + 3'd1;
                end
            end
            S_SIZE: begin
                flat_next = AW'(fprod) + pflat_reg;
                if (sprod > (CW+9)'(TABLE_ENTRIES)) begin
                    status_next = ST_RANGE;
                    state_next  = S_FIN;
                end else if (op_reg) begin
                    if (!ok_reg) begin
                        status_next = ST_RANGE;
                        state_next  = S_FIN;
                    end else begin
                        state_next = S_Q_RD;
                    end
                end else begin
                    status_next = ok_reg ? ST_OK : ST_RANGE;
                    if (first_reg) begin
                        fill_next  = '0;
                        state_next = S_FILL;
                    end else if (ok_reg) begin
                        state_next = S_ADD_RD;
                    end else if (last_reg) begin
                        col_next   = '0;
                        zero_next  = 1'b0;
                        state_next = S_NORM_COL;
                    end else begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = fill_reg;
                ram_wdata = smoothing_reg;
                zcs_next  = 1'b0;
                fill_next = fill_reg + AW'(1);
                if (fill_reg == AW'(TABLE_ENTRIES - 1)) begin
                    if (ok_reg) begin
                        state_next = S_ADD_RD;
                    end else if (last_reg) begin
                        col_next   = '0;
                        zero_next  = 1'b0;
                        state_next = S_NORM_COL;
                    end else begin
                        state_next = S_FIN;
                    end
                end
            end
            S_ADD_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = flat_reg;
                state_next = S_ADD_WR;
            end
            S_ADD_WR: begin
                ram_we    = 1'b1;
                ram_waddr = flat_reg;
                ram_wdata = sat_sum[CNT_W] ? '1 : sat_sum[CNT_W-1:0];
                if (last_reg) begin
                    col_next   = '0;
                    zero_next  = 1'b0;
                    state_next = S_NORM_COL;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_NORM_COL: begin
                vcnt_next  = '0;
                addr_next  = AW'(col_reg);
                sum_next   = '0;
                pend_next  = 1'b0;
                qpass_next = 1'b0;
                state_next = S_SUM;
            end
            S_SUM: begin
                // reads stream out one per cycle, data lands in the next cycle
                if (issue) begin
                    ram_re    = 1'b1;
                    ram_raddr = addr_reg;
                    addr_next = addr_reg + AW'(cols_reg);
                    vcnt_next = vcnt_reg + STATES_W'(1);
                end
                pend_next = issue;
                if (pend_reg) begin
                    sum_next = sum_reg + SUM_W'(ram_rdata);
                end
                if (!issue && !pend_reg) begin
                    state_next = S_SUM_DONE;
                end
            end
            S_SUM_DONE: begin
                if (qpass_reg) begin
                    if (sum_reg == '0) begin
                        status_next = ST_ZERO;
                        prob_next   = '0;
                    end
                    state_next = S_FIN;
                end else if (sum_reg == '0) begin
                    zero_next  = 1'b1;
                    state_next = S_NEXT_COL;
                end else begin
                    vcnt_next  = '0;
                    addr_next  = AW'(col_reg);
                    state_next = S_DIV_RD;
                end
            end
            S_DIV_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = addr_reg;
                state_next = S_DIV_GO;
            end
            S_DIV_GO: begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    ram_we    = 1'b1;
                    ram_waddr = addr_reg;
                    ram_wdata = CNT_W'(div_quot);
                    addr_next = addr_reg + AW'(cols_reg);
                    vcnt_next = vcnt_reg + STATES_W'(1);
                    if ((vcnt_reg + STATES_W'(1)) == ns_eff) begin
                        state_next = S_NEXT_COL;
                    end else begin
                        state_next = S_DIV_RD;
                    end
                end
            end
            S_NEXT_COL: begin
                if ((col_reg + CW'(1)) == cols_reg) begin
                    zcs_next = zero_reg;
                    if (ok_reg && zero_reg) begin
                        status_next = ST_ZERO;
                    end
                    state_next = S_FIN;
                end else begin
                    col_next   = col_reg + CW'(1);
                    state_next = S_NORM_COL;
                end
            end
            S_Q_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = flat_reg;
                state_next = S_Q_DATA;
            end
            S_Q_DATA: begin
                prob_next = (ram_rdata > CNT_W'(PROB_ONE)) ? PROB_ONE
                                                           : ram_rdata[PROB_W-1:0];
                if (zcs_reg) begin
                    // check the column of the queried entry for all zeros
                    vcnt_next  = '0;
                    addr_next  = pflat_reg;
                    sum_next   = '0;
                    pend_next  = 1'b0;
                    qpass_next = 1'b1;
                    state_next = S_SUM;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_prob_next   = prob_reg;
                    m_status_next = status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg            <= S_IDLE;
            zcs_reg              <= 1'b0;
            m_tvalid_reg         <= 1'b0;
            node_states_reg      <= STATES_W'(2);
            parent_count_reg     <= '0;
            parent_states_reg[0] <= STATES_W'(1);
            parent_states_reg[1] <= STATES_W'(1);
            parent_states_reg[2] <= STATES_W'(1);
            parent_states_reg[3] <= STATES_W'(1);
            smoothing_reg        <= CNT_W'(1 << FRAC_W);
        end else begin
            state_reg    <= state_next;
            zcs_reg      <= zcs_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_NODE_STATES: node_states_reg      <= cfg_wdata[STATES_W-1:0];
                    REG_PARENT_CNT:  parent_count_reg     <= cfg_wdata[2:0];
                    REG_PARENT0:     parent_states_reg[0] <= cfg_wdata[STATES_W-1:0];
                    REG_PARENT1:     parent_states_reg[1] <= cfg_wdata[STATES_W-1:0];
                    REG_PARENT2:     parent_states_reg[2] <= cfg_wdata[STATES_W-1:0];
                    REG_PARENT3:     parent_states_reg[3] <= cfg_wdata[STATES_W-1:0];
                    REG_SMOOTHING:   smoothing_reg        <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        first_reg    <= first_next;
        last_reg     <= last_next;
        nv_reg       <= nv_next;
        pv_reg       <= pv_next;
        w_reg        <= w_next;
        ok_reg       <= ok_next;
        pi_reg       <= pi_next;
        cols_reg     <= cols_next;
        pflat_reg    <= pflat_next;
        flat_reg     <= flat_next;
        fill_reg     <= fill_next;
        col_reg      <= col_next;
        vcnt_reg     <= vcnt_next;
        addr_reg     <= addr_next;
        sum_reg      <= sum_next;
        pend_reg     <= pend_next;
        qpass_reg    <= qpass_next;
        zero_reg     <= zero_next;
        prob_reg     <= prob_next;
        status_reg   <= status_next;
        m_prob_reg   <= m_prob_next;
        m_status_reg <= m_status_next;
    end

    cpt_table_ram #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (AW),
        .DATA_W (CNT_W)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cpt_divider #(
        .NUM_W (NUM_W),
        .DEN_W (SUM_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_numer),
        .denom   (sum_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = 24'(m_prob_reg);
    assign m_tuser  = m_status_reg;

endmodule
